// ===== sv/ccdm_pkg.sv =====
// Shared types and constants for the character-class automaton matcher.
// No dependencies; imported by every module of the block but ccdm_ram.
`timescale 1ns / 1ps

package ccdm_pkg;

  // Default table geometry
  localparam int NODE_COUNT_DEF     = 16;
  localparam int LINKS_PER_NODE_DEF = 4;

  // Fixed field widths of the stream and config words
  localparam int NODE_FW  = 4;
  localparam int KIND_FW  = 3;
  localparam int BYTE_FW  = 8;
  localparam int SLOT_FW  = 2;
  localparam int MODE_FW  = 2;
  localparam int MASK_FW  = 16;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 8;
  localparam int CFG_IDXW = 1;
  localparam int CFG_DW   = 16;

  // Packed class entry: kind, low bound, high bound
  localparam int CLASS_W = KIND_FW + 2 * BYTE_FW;
  // Packed link entry: valid flag, target node
  localparam int LINK_W  = NODE_FW + 1;

  typedef enum logic [MODE_FW-1:0] {
    MODE_CLASS   = 2'd0,
    MODE_LINK    = 2'd1,
    MODE_CHAR    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [KIND_FW-1:0] {
    KIND_NEVER   = 3'd0,
    KIND_ANY     = 3'd1,
    KIND_EXACT   = 3'd2,
    KIND_INSIDE  = 3'd3,
    KIND_OUTSIDE = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDXW-1:0] {
    REG_START_NODE = 1'd0,
    REG_END_MASK   = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [KIND_FW-1:0] kind;
    logic [BYTE_FW-1:0] low;
    logic [BYTE_FW-1:0] high;
  } class_t;

  typedef struct packed {
    logic               valid;
    logic [NODE_FW-1:0] target;
  } link_t;

endpackage

// ===== sv/ccdm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ccdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ccdm_class_cmp.sv =====
// Shared character-class compare unit: does a byte fall in a node's class.
// Depends on ccdm_pkg for the class entry type and kind codes.
`timescale 1ns / 1ps

module ccdm_class_cmp
  import ccdm_pkg::*;
(
  input  class_t              cls,
  input  logic [BYTE_FW-1:0]  char_byte,
  output logic                match
);

  logic ge_low;
  logic le_high;

  assign ge_low  = (char_byte >= cls.low);
  assign le_high = (char_byte <= cls.high);

  always_comb begin
    case (cls.kind)
      KIND_ANY:     match = 1'b1;
      KIND_EXACT:   match = (char_byte == cls.low);
      KIND_INSIDE:  match = ge_low && le_high;
      KIND_OUTSIDE: match = !ge_low || !le_high;
      default:      match = 1'b0; // never, and unused kinds
    endcase
  end

endmodule

// ===== sv/char_class_dfa_matcher.sv =====
// Character-class automaton matcher. A character word holds the block through S_LINK and S_TEST
// for each link slot tried (the shared class compare sits behind two RAM reads), then S_DONE;
// when halted it goes straight to S_DONE. Its result is put in the output register
// from S_DONE, which waits while the output register holds an earlier word not yet taken.
// Table, link and restart words give no word back; a new word is taken only once the last is done.
// rst_n starts a clearing pass over both tables, in_tready low; regs zero.
`timescale 1ns / 1ps

module char_class_dfa_matcher
  import ccdm_pkg::*;
#(
  parameter int NODE_COUNT     = NODE_COUNT_DEF,
  parameter int LINKS_PER_NODE = LINKS_PER_NODE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CFG_IDXW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // tdata, low bit up: node_index[3:0], class_kind[6:4], class_low[14:7],
  // class_high[22:15], slot_index[24:23], link_target[28:25], link_valid[29],
  // char_byte[37:30], zero fill[39:38]
  input  logic [IN_DW-1:0]    in_tdata,
  // tuser: mode[1:0]
  input  logic [MODE_FW-1:0]  in_tuser,
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // tdata, low bit up: current_node[3:0], halted[4], accepted[5], zero fill[7:6]
  output logic [OUT_DW-1:0]   out_tdata
);

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SLOT_DEPTH = NODE_COUNT * LINKS_PER_NODE;
  localparam int SA_W       = $clog2(SLOT_DEPTH);
  localparam int SLOT_W     = (LINKS_PER_NODE > 1) ? $clog2(LINKS_PER_NODE) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,  // zeroing both tables after reset
    S_IDLE,   // taking words
    S_LINK,   // link entry on the read port, fetch its target's class
    S_TEST,   // class entry on the read port, compare against the byte
    S_DONE    // result waiting for room in the output register
  } state_t;

  // ---------------------------------------------------------------------
  // Input word unpacking
  // ---------------------------------------------------------------------
  mode_t              in_mode;
  logic [NODE_FW-1:0] in_node;
  class_t             in_class;
  logic [SLOT_FW-1:0] in_slot;
  link_t              in_link;
  logic [BYTE_FW-1:0] in_byte;

  assign in_mode        = mode_t'(in_tuser);
  assign in_node        = in_tdata[3:0];
  assign in_class.kind  = in_tdata[6:4];
  assign in_class.low   = in_tdata[14:7];
  assign in_class.high  = in_tdata[22:15];
  assign in_slot        = in_tdata[24:23];
  assign in_link.target = in_tdata[28:25];
  assign in_link.valid  = in_tdata[29];
  assign in_byte        = in_tdata[37:30];

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_t              state_r,     state_nxt;
  logic [SA_W-1:0]     clr_r,       clr_nxt;
  logic [SLOT_W-1:0]   slot_r,      slot_nxt;
  logic [NODE_FW-1:0]  present_r,   present_nxt;
  logic                stopped_r,   stopped_nxt;
  logic [BYTE_FW-1:0]  byte_r,      byte_nxt;
  logic                link_ok_r,   link_ok_nxt;
  logic [NODE_FW-1:0]  link_tgt_r,  link_tgt_nxt;
  logic [NODE_FW-1:0]  start_node_r;
  logic [MASK_FW-1:0]  end_mask_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]   out_data_r,  out_data_nxt;

  // ---------------------------------------------------------------------
  // Tables: class per node, link entry per node and slot
  // ---------------------------------------------------------------------
  logic              cls_we;
  logic [NODE_W-1:0] cls_waddr, cls_raddr;
  class_t            cls_wdata, cls_rdata;
  logic              lnk_we;
  logic [SA_W-1:0]   lnk_waddr, lnk_raddr;
  link_t             lnk_wdata, lnk_rdata;

  ccdm_ram #(.WIDTH(CLASS_W), .DEPTH(NODE_COUNT)) u_class_ram (
    .clk   (clk),
    .we    (cls_we),
    .waddr (cls_waddr),
    .wdata (cls_wdata),
    .raddr (cls_raddr),
    .rdata (cls_rdata)
  );

  ccdm_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_rdata)
  );

  // Shared compare unit, reused for every slot tried
  logic cmp_match;

  ccdm_class_cmp u_cmp (
    .cls       (cls_rdata),
    .char_byte (byte_r),
    .match     (cmp_match)
  );

  // ---------------------------------------------------------------------
  // Range checks and addresses
  // ---------------------------------------------------------------------
  logic            in_node_ok;
  logic            in_slot_ok;
  logic            present_ok;
  logic            rd_tgt_ok;
  logic            last_slot;
  logic            in_acc;
  logic [31:0]     rd_slot_sel;

  assign in_node_ok = (32'(in_node) < NODE_COUNT);
  assign in_slot_ok = (32'(in_slot) < LINKS_PER_NODE);
  assign present_ok = (32'(present_r) < NODE_COUNT);
  assign rd_tgt_ok  = (32'(lnk_rdata.target) < NODE_COUNT);
  assign last_slot  = (32'(slot_r) == LINKS_PER_NODE - 1);

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  // slot 0 when a character starts, else the slot after the one under test
  assign rd_slot_sel = (state_r == S_IDLE) ? 32'd0 : 32'(slot_r) + 32'd1;
  assign lnk_raddr   = SA_W'(32'(present_r) * LINKS_PER_NODE + rd_slot_sel);
  assign cls_raddr   = NODE_W'(lnk_rdata.target);

  // Write ports: clearing pass, or load words
  always_comb begin
    cls_we    = 1'b0;
    cls_waddr = NODE_W'(in_node);
    cls_wdata = in_class;
    lnk_we    = 1'b0;
    lnk_waddr = SA_W'(32'(in_node) * LINKS_PER_NODE + 32'(in_slot));
    lnk_wdata = in_link;
    if (state_r == S_CLEAR) begin
      cls_we    = (32'(clr_r) < NODE_COUNT);
      cls_waddr = NODE_W'(clr_r);
      cls_wdata = '0;
      lnk_we    = 1'b1;
      lnk_waddr = clr_r;
      lnk_wdata = '0;
    end else if (in_acc) begin
      cls_we = (in_mode == MODE_CLASS) && in_node_ok;
      lnk_we = (in_mode == MODE_LINK) && in_node_ok && in_slot_ok;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    present_nxt   = present_r;
    stopped_nxt   = stopped_r;
    byte_nxt      = byte_r;
    link_ok_nxt   = link_ok_r;
    link_tgt_nxt  = link_tgt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == SLOT_DEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_RESTART: begin
              present_nxt = start_node_r;
              stopped_nxt = 1'b0;
            end
            MODE_CHAR: begin
              byte_nxt = in_byte;
              slot_nxt = '0;
              // halted, or a start node past the table: nothing to walk
              if (stopped_r || !present_ok) begin
                stopped_nxt = 1'b1;
                state_nxt   = S_DONE;
              end else begin
                state_nxt = S_LINK;
              end
            end
            default: ; // table writes go straight to the RAMs
          endcase
        end
      end
      S_LINK: begin
        link_ok_nxt  = lnk_rdata.valid && rd_tgt_ok;
        link_tgt_nxt = lnk_rdata.target;
        state_nxt    = S_TEST;
      end
      S_TEST: begin
        if (link_ok_r && cmp_match) begin
          present_nxt = link_tgt_r;
          state_nxt   = S_DONE;
        end else if (last_slot) begin
          stopped_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_LINK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, end_mask_r[present_r], stopped_r, present_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      present_r   <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      present_r   <= present_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    byte_r     <= byte_nxt;
    link_ok_r  <= link_ok_nxt;
    link_tgt_r <= link_tgt_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_node_r <= '0;
      end_mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_START_NODE: start_node_r <= cfg_wdata[NODE_FW-1:0];
        REG_END_MASK:   end_mask_r   <= cfg_wdata[MASK_FW-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== dv/char_class_dfa_matcher_monitor.sv =====
// Watches the config port and both streams of char_class_dfa_matcher, predicts each result word
// from its own copy of the node and link tables, and compares field by field.
// Depends on ccdm_pkg for widths, modes, class kinds and register indexes.
`timescale 1ns / 1ps

module char_class_dfa_matcher_monitor
  import ccdm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IDXW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [IN_DW-1:0]    in_tdata,
  input  logic [MODE_FW-1:0]  in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OUT_DW-1:0]   out_tdata,
  output int                  pending,
  output int                  failures
);

  localparam int NODES = NODE_COUNT_DEF;
  localparam int LINKS = LINKS_PER_NODE_DEF;

  typedef struct packed {
    logic [NODE_FW-1:0] node;
    logic               halted;
    logic               accepted;
  } move_t;

  logic [KIND_FW-1:0] cls_kind [NODES];
  logic [BYTE_FW-1:0] cls_low  [NODES];
  logic [BYTE_FW-1:0] cls_high [NODES];
  logic [NODE_FW-1:0] lnk_target [NODES][LINKS];
  logic               lnk_valid  [NODES][LINKS];
  logic [NODE_FW-1:0] node_now;
  logic               halted_now;
  logic [NODE_FW-1:0] start_reg;
  logic [MASK_FW-1:0] end_reg;
  move_t              awaited_moves [$];
  move_t              seen;
  move_t              want;
  int                 i;
  int                 j;

  function automatic logic class_admits(input logic [NODE_FW-1:0] n,
                                        input logic [BYTE_FW-1:0] ch);
    case (cls_kind[n])
      KIND_ANY:     return 1'b1;
      KIND_EXACT:   return ch == cls_low[n];
      KIND_INSIDE:  return ch >= cls_low[n] && ch <= cls_high[n];
      KIND_OUTSIDE: return ch < cls_low[n] || ch > cls_high[n];
      default:      return 1'b0;
    endcase
  endfunction

  // Update the tables, restart the walk, or walk one character; a character always yields one word.
  task automatic step_automaton(input logic [MODE_FW-1:0] mode, input logic [IN_DW-1:0] d);
    logic [NODE_FW-1:0] n;
    logic [SLOT_FW-1:0] slot;
    logic [NODE_FW-1:0] tgt;
    logic               found;
    move_t              mv;
    int                 s;
    n    = d[3:0];
    slot = d[24:23];
    case (mode)
      MODE_CLASS: begin
        cls_kind[n] = d[6:4];
        cls_low[n]  = d[14:7];
        cls_high[n] = d[22:15];
      end
      MODE_LINK: begin
        lnk_target[n][slot] = d[28:25];
        lnk_valid[n][slot]  = d[29];
      end
      MODE_RESTART: begin
        node_now   = start_reg;
        halted_now = 1'b0;
      end
      MODE_CHAR: begin
        if (!halted_now) begin
          found = 1'b0;
          for (s = 0; s < LINKS && !found; s++) begin
            tgt = lnk_target[node_now][s];
            if (lnk_valid[node_now][s] && class_admits(tgt, d[37:30])) begin
              node_now = tgt;
              found    = 1'b1;
            end
          end
          if (!found) halted_now = 1'b1;
        end
        mv = '{node_now, halted_now, end_reg[node_now]};
        awaited_moves.insert(awaited_moves.size(), mv);
      end
    endcase
  endtask

  task automatic log_failure(input logic unexpected, input move_t w, input move_t g);
    failures++;
    if (failures <= 10) begin
      if (unexpected)
        $display("%0t: unexpected word node %0d halted %0b accepted %0b",
                 $realtime, g.node, g.halted, g.accepted);
      else
        $display("%0t: expected node %0d halted %0b acc %0b, got node %0d halted %0b acc %0b",
                 $realtime, w.node, w.halted, w.accepted, g.node, g.halted, g.accepted);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (i = 0; i < NODES; i++) begin
        cls_kind[i] = KIND_NEVER;
        cls_low[i]  = '0;
        cls_high[i] = '0;
        for (j = 0; j < LINKS; j++) begin
          lnk_target[i][j] = '0;
          lnk_valid[i][j]  = 1'b0;
        end
      end
      node_now   = '0;
      halted_now = 1'b0;
      start_reg  = '0;
      end_reg    = '0;
      awaited_moves.delete();
      failures   = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_START_NODE) start_reg = cfg_wdata[NODE_FW-1:0];
        else if (cfg_idx == REG_END_MASK) end_reg = cfg_wdata[MASK_FW-1:0];
      end
      if (out_tvalid && out_tready) begin
        // word holds node in the low bits, then halted, then accepted
        seen = {out_tdata[3:0], out_tdata[4], out_tdata[5]};
        if (awaited_moves.size() == 0) begin
          log_failure(1'b1, '0, seen);
        end else begin
          want = awaited_moves.pop_front();
          if (seen.node != want.node || seen.halted != want.halted ||
              seen.accepted != want.accepted)
            log_failure(1'b0, want, seen);
        end
      end
      if (in_tvalid && in_tready) step_automaton(in_tuser, in_tdata);
    end
    pending <= awaited_moves.size();
  end

endmodule

// ===== dv/char_class_dfa_matcher_test.sv =====
// Top of the char_class_dfa_matcher bench: clock, reset, config writes, input and result
// stream drivers and the verdict. Needs ccdm_pkg, the block and char_class_dfa_matcher_monitor.
`timescale 1ns / 1ps

module char_class_dfa_matcher_test;
  import ccdm_pkg::*;

  localparam logic [BYTE_FW-1:0] STAR = 8'h2A;  // '*'
  localparam int DRAIN = 12;                     // > longest character walk

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IDXW-1:0] cfg_idx;
  logic [CFG_DW-1:0]   cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic [MODE_FW-1:0]  in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  int                  pending;
  int                  failures;

  // no idling on either side while set
  bit                  calm;
  // recent class bounds, so characters land on and around them
  logic [BYTE_FW-1:0]  hot_bytes [32];
  logic [4:0]          hot_at;

  char_class_dfa_matcher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  char_class_dfa_matcher_monitor watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .failures   (failures)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // tdata, low bit up: node, kind, low, high, slot, target, valid, char, zero fill
  function automatic logic [IN_DW-1:0] pack_word(
      input logic [NODE_FW-1:0] n, input logic [KIND_FW-1:0] k,
      input logic [BYTE_FW-1:0] lo, input logic [BYTE_FW-1:0] hi,
      input logic [SLOT_FW-1:0] slot, input logic [NODE_FW-1:0] tgt,
      input logic v, input logic [BYTE_FW-1:0] ch);
    return {2'b00, ch, v, tgt, slot, hi, lo, k, n};
  endfunction

  // One word on the input stream; holds tvalid high across back-to-back words.
  task automatic send(input mode_t m, input logic [IN_DW-1:0] d);
    int unsigned g;
    g = pause_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Fields a mode does not use carry random junk.
  task automatic put_class(input logic [NODE_FW-1:0] n, input logic [KIND_FW-1:0] k,
                           input logic [BYTE_FW-1:0] lo, input logic [BYTE_FW-1:0] hi);
    hot_bytes[hot_at] = lo;
    hot_bytes[hot_at + 5'd1] = hi;
    hot_at += 5'd2;
    send(MODE_CLASS, pack_word(n, k, lo, hi, SLOT_FW'($urandom), NODE_FW'($urandom),
                               1'($urandom), BYTE_FW'($urandom)));
  endtask

  task automatic put_link(input logic [NODE_FW-1:0] n, input logic [SLOT_FW-1:0] slot,
                          input logic [NODE_FW-1:0] tgt, input logic v);
    send(MODE_LINK, pack_word(n, KIND_FW'($urandom), BYTE_FW'($urandom), BYTE_FW'($urandom),
                              slot, tgt, v, BYTE_FW'($urandom)));
  endtask

  task automatic put_char(input logic [BYTE_FW-1:0] ch);
    send(MODE_CHAR, pack_word(NODE_FW'($urandom), KIND_FW'($urandom), BYTE_FW'($urandom),
                              BYTE_FW'($urandom), SLOT_FW'($urandom), NODE_FW'($urandom),
                              1'($urandom), ch));
  endtask

  task automatic put_restart();
    send(MODE_RESTART, pack_word(NODE_FW'($urandom), KIND_FW'($urandom), BYTE_FW'($urandom),
                                 BYTE_FW'($urandom), SLOT_FW'($urandom), NODE_FW'($urandom),
                                 1'($urandom), BYTE_FW'($urandom)));
  endtask

  // Mostly real classes with ordered ranges; some never, unknown kinds or inverted ranges.
  task automatic random_class();
    logic [KIND_FW-1:0] k;
    logic [BYTE_FW-1:0] lo;
    logic [BYTE_FW-1:0] hi;
    logic [BYTE_FW-1:0] t;
    int unsigned        r;
    r  = $urandom_range(0, 99);
    k  = (r < 10) ? KIND_FW'($urandom_range(5, 7)) :
         (r < 18) ? KIND_NEVER : KIND_FW'($urandom_range(1, 4));
    lo = BYTE_FW'($urandom);
    hi = BYTE_FW'($urandom);
    if (lo > hi && $urandom_range(0, 99) < 80) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    put_class(NODE_FW'($urandom_range(0, 15)), k, lo, hi);
  endtask

  task automatic random_link();
    put_link(NODE_FW'($urandom_range(0, 15)), SLOT_FW'($urandom_range(0, 3)),
             NODE_FW'($urandom_range(0, 15)), $urandom_range(0, 99) < 85);
  endtask

  task automatic random_char();
    if ($urandom_range(0, 1))
      put_char(hot_bytes[$urandom_range(0, 31)] + BYTE_FW'($urandom_range(0, 2)) - 8'd1);
    else
      put_char(BYTE_FW'($urandom));
  endtask

  // Let the block go idle, then write both registers.
  task automatic reprogram(input logic [NODE_FW-1:0] s, input logic [MASK_FW-1:0] m);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_START_NODE;
    cfg_wdata <= {{(CFG_DW-NODE_FW){1'b0}}, s};
    @(posedge clk);
    cfg_idx   <= REG_END_MASK;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: tready drops for random stretches unless calm.
  initial begin
    int unsigned n;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      n = pause_len();
      if (n == 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int ph;
    int k;
    int unsigned r;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_START_NODE;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_CLASS;
    calm      = 1'b0;
    hot_at    = '0;
    foreach (hot_bytes[i]) hot_bytes[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: nodes 2 and 5 accept
    reprogram(4'd0, 16'h0024);
    put_char(8'h00);                          // cleared tables: no links, halts at node 0
    put_char(8'hFF);                          // ignored while halted
    put_restart();
    put_class(4'd0, KIND_ANY, 8'h00, 8'hFF);
    put_class(4'd1, KIND_EXACT, STAR, 8'h00);
    put_class(4'd2, KIND_INSIDE, 8'h30, 8'h39);
    put_class(4'd3, KIND_OUTSIDE, 8'h00, 8'h7F);
    put_class(4'd4, KIND_INSIDE, 8'hC8, 8'h64);   // inverted: matches nothing
    put_class(4'd5, KIND_OUTSIDE, 8'hC8, 8'h64);  // inverted: matches everything
    put_class(4'd15, 3'd7, 8'hFF, 8'hFF);         // unknown kind never matches
    put_link(4'd0, 2'd0, 4'd1, 1'b1);
    put_link(4'd0, 2'd1, 4'd2, 1'b1);
    put_link(4'd0, 2'd2, 4'd3, 1'b1);
    put_link(4'd0, 2'd3, 4'd15, 1'b1);
    put_link(4'd1, 2'd0, 4'd4, 1'b1);
    put_link(4'd1, 2'd1, 4'd5, 1'b1);
    put_link(4'd5, 2'd0, 4'd0, 1'b1);
    put_link(4'd5, 2'd3, 4'd15, 1'b0);
    put_restart();
    put_char(STAR);                           // 0 -> 1
    put_char(8'h00);                          // inverted inside skipped, 1 -> 5
    put_char(8'hFF);                          // 5 -> 0
    put_char(8'h35);                          // first slot misses, 0 -> 2
    put_char(8'h80);                          // node 2 has no links: halt

    // Random phases; each begins with a drained pipe and fresh registers
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       reprogram(4'd0, 16'hFFFF);
        1:       reprogram(4'd15, 16'h0000);
        2:       reprogram(4'd15, 16'h8001);
        default: reprogram(NODE_FW'($urandom), MASK_FW'($urandom));
      endcase
      calm = (ph == 3);
      for (k = 0; k < 12; k++) random_class();
      for (k = 0; k < 24; k++) random_link();
      put_restart();
      for (k = 0; k < 200; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) random_class();
        else if (r < 8) random_link();
        else if (r < 20) put_restart();
        else random_char();
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    if (failures == 0)
      $display("char_class_dfa_matcher_test passed");
    else
      $display("char_class_dfa_matcher_test failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("char_class_dfa_matcher_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ccdm_pkg.sv
sv/ccdm_ram.sv
sv/ccdm_class_cmp.sv
sv/char_class_dfa_matcher.sv
dv/char_class_dfa_matcher_monitor.sv
dv/char_class_dfa_matcher_test.sv
